// ----- design/vmp_pkg.sv -----
// shared types and codes for the vector matrix product block
`default_nettype none

package vmp_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned CountW = 5;

  localparam logic [1:0] ACT_VECTOR  = 2'd0;
  localparam logic [1:0] ACT_MATRIX  = 2'd1;
  localparam logic [1:0] ACT_COMPUTE = 2'd2;

  localparam logic REG_COLUMN_COUNT = 1'b0;
  localparam logic REG_ROW_COUNT    = 1'b1;

  typedef struct packed {
    logic            valid;
    logic            first_row;
    logic            last_row;
    logic            last_col;
    logic [IdxW-1:0] col;
  } ctl_t;

endpackage

`default_nettype wire

// ----- design/vmp_ram.sv -----
// generic single write port, single read port ram with registered read
`default_nettype none

module vmp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- design/vmp_seq.sv -----
// read sequencer walking rows inside columns for one compute transaction
`default_nettype none

module vmp_seq #(
  parameter int unsigned MAX_DIM = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [vmp_pkg::CountW-1:0]   col_count_i,
  input  wire logic [vmp_pkg::CountW-1:0]   row_count_i,
  output logic      [vmp_pkg::IdxW-1:0]     row_o,
  output logic      [vmp_pkg::IdxW-1:0]     col_o,
  output vmp_pkg::ctl_t                     ctl_o,
  output logic                              run_o
);

  import vmp_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  localparam logic [CountW-1:0] DimLimit = CountW'(MAX_DIM < 16 ? MAX_DIM : 16);

  logic              state_q, state_d;
  logic [IdxW-1:0]   row_q, row_d;
  logic [IdxW-1:0]   col_q, col_d;
  logic [IdxW-1:0]   last_row_q, last_row_d;
  logic [IdxW-1:0]   last_col_q, last_col_d;
  logic [CountW-1:0] rows_clamped;
  logic [CountW-1:0] cols_clamped;
  logic              at_last_row;
  logic              at_last_col;

  always_comb begin
    priority if (row_count_i == '0) begin
      rows_clamped = CountW'(1);
    end else if (row_count_i > DimLimit) begin
      rows_clamped = DimLimit;
    end else begin
      rows_clamped = row_count_i;
    end
    priority if (col_count_i == '0) begin
      cols_clamped = CountW'(1);
    end else if (col_count_i > DimLimit) begin
      cols_clamped = DimLimit;
    end else begin
      cols_clamped = col_count_i;
    end
  end

  assign at_last_row = (row_q == last_row_q);
  assign at_last_col = (col_q == last_col_q);

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    last_row_d = last_row_q;
    last_col_d = last_col_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d    = ST_RUN;
          row_d      = '0;
          col_d      = '0;
          last_row_d = IdxW'(rows_clamped - CountW'(1));
          last_col_d = IdxW'(cols_clamped - CountW'(1));
        end
      end
      ST_RUN: begin
        if (at_last_row) begin
          row_d = '0;
          if (at_last_col) begin
            state_d = ST_IDLE;
          end else begin
            col_d = col_q + IdxW'(1);
          end
        end else begin
          row_d = row_q + IdxW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      row_q      <= '0;
      col_q      <= '0;
      last_row_q <= '0;
      last_col_q <= '0;
    end else begin
      state_q    <= state_d;
      row_q      <= row_d;
      col_q      <= col_d;
      last_row_q <= last_row_d;
      last_col_q <= last_col_d;
    end
  end

  assign row_o           = row_q;
  assign col_o           = col_q;
  assign run_o           = (state_q == ST_RUN);
  assign ctl_o.valid     = (state_q == ST_RUN);
  assign ctl_o.first_row = (row_q == '0);
  assign ctl_o.last_row  = at_last_row;
  assign ctl_o.last_col  = at_last_col;
  assign ctl_o.col       = col_q;

endmodule

`default_nettype wire

// ----- design/vmp_mac.sv -----
// multiply accumulate datapath with result registers
`default_nettype none

module vmp_mac (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire vmp_pkg::ctl_t               ctl_i,
  input  wire logic [vmp_pkg::DataW-1:0]   vec_data_i,
  input  wire logic [vmp_pkg::DataW-1:0]   mat_data_i,
  output logic                             pending_o,
  output logic                             res_valid_o,
  output logic      [vmp_pkg::IdxW-1:0]    res_col_o,
  output logic      [vmp_pkg::DataW-1:0]   res_sum_o,
  output logic                             res_last_o
);

  import vmp_pkg::*;

  ctl_t               ctl1_q;
  ctl_t               ctl2_q;
  logic [2*DataW-1:0] prod_full;
  logic [DataW-1:0]   prod_q;
  logic [DataW-1:0]   acc_q, acc_d;
  logic               res_valid_q;
  logic [IdxW-1:0]    res_col_q;
  logic [DataW-1:0]   res_sum_q;
  logic               res_last_q;

  assign prod_full = (2*DataW)'(vec_data_i) * (2*DataW)'(mat_data_i);
  assign acc_d     = (ctl2_q.first_row ? '0 : acc_q) + prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q      <= '0;
      ctl2_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      ctl1_q      <= ctl_i;
      ctl2_q      <= ctl1_q;
      res_valid_q <= ctl2_q.valid && ctl2_q.last_row;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_full[DataW-1:0];
    if (ctl2_q.valid) begin
      acc_q <= acc_d;
    end
    if (ctl2_q.valid && ctl2_q.last_row) begin
      res_col_q  <= ctl2_q.col;
      res_sum_q  <= acc_d;
      res_last_q <= ctl2_q.last_col;
    end
  end

  assign pending_o   = ctl1_q.valid || ctl2_q.valid;
  assign res_valid_o = res_valid_q;
  assign res_col_o   = res_col_q;
  assign res_sum_o   = res_sum_q;
  assign res_last_o  = res_last_q;

endmodule

`default_nettype wire

// ----- design/vector_matrix_product.sv -----
// top level of the vector matrix product engine
// load transactions keep busy low
// a compute keeps busy high until the mac has drained, one memory read per cycle
// one result per column in column order, each registered with its column's final sum
// results are single-cycle strobes; the receiver cannot stall
// reset sets both counts to 16 and clears control; store contents are undefined until written
`default_nettype none

module vector_matrix_product #(
  parameter int unsigned MAX_DIM = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_idx_i,
  input  wire logic [vmp_pkg::CountW-1:0]   cfg_data_i,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   action_i,
  input  wire logic [vmp_pkg::IdxW-1:0]     row_index_i,
  input  wire logic [vmp_pkg::IdxW-1:0]     col_index_i,
  input  wire logic signed [vmp_pkg::DataW-1:0] value_i,
  output logic                              result_valid_o,
  output logic      [vmp_pkg::IdxW-1:0]     column_o,
  output logic signed [vmp_pkg::DataW-1:0]  sum_o,
  output logic                              last_o
);

  import vmp_pkg::*;

  localparam int unsigned VAddrW = $clog2(MAX_DIM);
  localparam int unsigned MAddrW = $clog2(MAX_DIM * MAX_DIM);
  localparam int unsigned CalcW  = MAddrW + IdxW + 1;

  logic [CountW-1:0] column_count_q;
  logic [CountW-1:0] row_count_q;

  logic              accept;
  logic              row_ok;
  logic              col_ok;
  logic              vec_we;
  logic              mat_we;
  logic              compute_go;
  logic [CalcW-1:0]  mat_waddr_full;
  logic [CalcW-1:0]  mat_raddr_full;
  logic [IdxW-1:0]   seq_row;
  logic [IdxW-1:0]   seq_col;
  ctl_t              seq_ctl;
  logic              seq_run;
  logic              mac_pending;
  logic [DataW-1:0]  vec_rdata;
  logic [DataW-1:0]  mat_rdata;
  logic [DataW-1:0]  res_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= CountW'(16);
      row_count_q    <= CountW'(16);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_COLUMN_COUNT: column_count_q <= cfg_data_i;
        REG_ROW_COUNT:    row_count_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy       = seq_run || mac_pending;
  assign accept     = start && !busy;
  assign row_ok     = (32'(row_index_i) < 32'(MAX_DIM));
  assign col_ok     = (32'(col_index_i) < 32'(MAX_DIM));
  assign vec_we     = accept && (action_i == ACT_VECTOR) && row_ok;
  assign mat_we     = accept && (action_i == ACT_MATRIX) && row_ok && col_ok;
  assign compute_go = accept && (action_i == ACT_COMPUTE);

  assign mat_waddr_full = CalcW'(row_index_i) * CalcW'(MAX_DIM) + CalcW'(col_index_i);
  assign mat_raddr_full = CalcW'(seq_row) * CalcW'(MAX_DIM) + CalcW'(seq_col);

  vmp_seq #(
    .MAX_DIM (MAX_DIM)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (compute_go),
    .col_count_i (column_count_q),
    .row_count_i (row_count_q),
    .row_o       (seq_row),
    .col_o       (seq_col),
    .ctl_o       (seq_ctl),
    .run_o       (seq_run)
  );

  vmp_ram #(
    .WIDTH (DataW),
    .DEPTH (MAX_DIM)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (vec_we),
    .waddr_i (VAddrW'(row_index_i)),
    .wdata_i (value_i),
    .raddr_i (VAddrW'(seq_row)),
    .rdata_o (vec_rdata)
  );

  vmp_ram #(
    .WIDTH (DataW),
    .DEPTH (MAX_DIM * MAX_DIM)
  ) u_mat_ram (
    .clk_i   (clk_i),
    .we_i    (mat_we),
    .waddr_i (mat_waddr_full[MAddrW-1:0]),
    .wdata_i (value_i),
    .raddr_i (mat_raddr_full[MAddrW-1:0]),
    .rdata_o (mat_rdata)
  );

  vmp_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (seq_ctl),
    .vec_data_i  (vec_rdata),
    .mat_data_i  (mat_rdata),
    .pending_o   (mac_pending),
    .res_valid_o (result_valid_o),
    .res_col_o   (column_o),
    .res_sum_o   (res_sum),
    .res_last_o  (last_o)
  );

  assign sum_o = res_sum;

  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    compute_go |=> busy)
    else $error("compute transaction did not raise busy");

  a_more_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> busy)
    else $error("busy dropped before the last result");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !result_valid_o)
    else $error("result directly after the last result");

  a_no_load_write_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_run |-> !(vec_we || mat_we))
    else $error("store written while a compute is reading");

endmodule

`default_nettype wire
